// File: src/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

    localparam int POS_W  = 32;   // Q16.16 coordinate
    localparam int MAG_W  = 66;   // magnitude of an exact cross product component
    localparam int M_W    = 30;   // scaled magnitude fed to the length computation
    localparam int Q_W    = 15;   // quotient bits of one normalized component
    localparam int NORM_W = 16;   // Q1.14 output component
    localparam int IDX_W  = 12;

    localparam int NORM_ONE = 16384;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD = 2'd0;
    localparam t_op OP_FACE = 2'd1;
    localparam t_op OP_READ = 2'd2;

    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic signed [NORM_W-1:0] t_norm;
    typedef t_norm [2:0]              t_nvec;

    // Sign and magnitude of a three component vector.
    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_vec;

endpackage

// File: src/vertex_normal_accumulator_top.sv
// Vertex normal accumulator: per-vertex normals averaged from face normals.
//
// Each vertex owns one position entry (three Q16.16 coordinates) and one normal
// sum entry (three saturating SUM_WIDTH-bit Q1.14 sums), both in on-chip RAM
// with a registered read. One item is worked at a time. A load transfer writes
// both entries in the accept cycle, and the block stays idle. A face transfer
// reads its three positions, forms the cross product in a shared 33x33
// multiplier and, if the product is nonzero, normalizes it and
// read-modify-writes the three sums; a degenerate face adds nothing. A read
// transfer fetches one sum, normalizes it unless it is zero, and then waits
// only while the output register still holds an untaken result. The square
// root of the normalizer gives one bit a cycle and its divider one quotient
// bit a cycle. Loads, faces or reads with an index at or above MAX_VERTICES,
// and op code 3, are dropped without a result. A face or read that names a
// vertex never loaded since reset returns unspecified data.
module vertex_normal_accumulator_top #(
    parameter int MAX_VERTICES = 4096,
    parameter int SUM_WIDTH    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_op,
    input  logic [11:0]         i_vertex_index,
    input  logic [11:0]         i_corner_a,
    input  logic [11:0]         i_corner_b,
    input  logic [11:0]         i_corner_c,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [11:0]         o_read_index,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic                o_zero_sum
);

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int PW   = vna_pkg::POS_W;
    localparam int SW   = SUM_WIDTH;
    localparam logic signed [SW:0] SUM_HI = {2'b00, {(SW-1){1'b1}}};
    localparam logic signed [SW:0] SUM_LO = {2'b11, {(SW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRD0,
        S_FRD1,
        S_FRD2,
        S_FRD3,
        S_FCROSS,
        S_FNORM,
        S_FSRD,
        S_FSWR,
        S_RRD,
        S_RCHK,
        S_RNORM,
        S_ROUT
    } t_state;

    function automatic logic [AW-1:0] to_addr(input logic [vna_pkg::IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [vna_pkg::IDX_W-1:0] v);
        return 32'(v) < 32'(MAX_VERTICES);
    endfunction

    function automatic logic [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                              input vna_pkg::t_norm b);
        logic signed [SW:0] t;
        t = (SW+1)'(a) + (SW+1)'(b);
        if (t > SUM_HI) begin
            t = SUM_HI;
        end else if (t < SUM_LO) begin
            t = SUM_LO;
        end
        return t[SW-1:0];
    endfunction

    t_state                     r_state;
    logic [AW-1:0]              r_ca;
    logic [AW-1:0]              r_cb;
    logic [AW-1:0]              r_cc;
    logic [vna_pkg::IDX_W-1:0]  r_idx;
    logic [3*PW-1:0]            r_p0;
    logic [3*PW-1:0]            r_p1;
    logic [3*PW-1:0]            r_p2;
    logic [1:0]                 r_k;
    vna_pkg::t_nvec             r_n;
    logic                       r_zero;
    vna_pkg::t_vec              r_norm_in;
    logic                       r_cross_start;
    logic                       r_norm_start;
    logic                       r_ovalid;
    logic [vna_pkg::IDX_W-1:0]  r_oidx;
    vna_pkg::t_nvec             r_onorm;
    logic                       r_ozero;

    logic                       w_in_acc;
    logic                       w_load;
    logic [AW-1:0]              w_corner;
    logic [AW-1:0]              w_pos_raddr;
    logic [3*PW-1:0]            w_pos_rdata;
    logic                       w_sum_we;
    logic [AW-1:0]              w_sum_waddr;
    logic [AW-1:0]              w_sum_raddr;
    logic [3*SW-1:0]            w_sum_wdata;
    logic [3*SW-1:0]            w_sum_rdata;
    logic signed [SW-1:0]       w_sum [3];
    logic                       w_sum_zero;
    vna_pkg::t_vec              w_sum_vec;
    logic                       w_cross_done;
    vna_pkg::t_vec              w_cross_vec;
    logic                       w_norm_done;
    vna_pkg::t_nvec             w_norm;
    logic                       w_norm_go;
    logic                       w_out_load;

    // Take a new transfer only between items.
    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;
    assign w_load   = w_in_acc && (i_op == vna_pkg::OP_LOAD) && in_range(i_vertex_index);

    // Start the normalizer on a nonzero cross product or a nonzero read sum.
    assign w_norm_go = (r_state == S_FCROSS && w_cross_done && w_cross_vec.mag != '0) ||
                       (r_state == S_RCHK && !w_sum_zero);

    // Advance the result into the output register once it is free.
    assign w_out_load = (r_state == S_ROUT) && (!r_ovalid || !i_stall);

    always_comb begin
        case (r_k)
            2'd0:    w_corner = r_ca;
            2'd1:    w_corner = r_cb;
            default: w_corner = r_cc;
        endcase
    end

    always_comb begin
        case (r_state)
            S_FRD1:  w_pos_raddr = r_cb;
            S_FRD2:  w_pos_raddr = r_cc;
            default: w_pos_raddr = r_ca;
        endcase
    end

    // Sum store: a load clears the entry, a face writes back the saturated sum.
    assign w_sum_raddr = (r_state == S_FSRD) ? w_corner : to_addr(r_idx);
    assign w_sum_we    = w_load || (r_state == S_FSWR);
    assign w_sum_waddr = w_load ? to_addr(i_vertex_index) : w_corner;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = signed'(w_sum_rdata[i*SW +: SW]);
        end
        w_sum_zero = (w_sum_rdata == '0);
        if (w_load) begin
            w_sum_wdata = '0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                w_sum_wdata[i*SW +: SW] = sat_add(w_sum[i], r_n[i]);
            end
        end
    end

    always_comb begin
        logic signed [SW:0] e;
        logic signed [SW:0] a;
        for (int i = 0; i < 3; i++) begin
            e                = (SW+1)'(w_sum[i]);
            w_sum_vec.neg[i] = w_sum[i] < 0;
            a                = w_sum_vec.neg[i] ? -e : e;
            w_sum_vec.mag[i] = vna_pkg::t_mag'($unsigned(a));
        end
    end

    vna_ram #(
        .WIDTH (3*PW),
        .DEPTH (MAX_VERTICES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (to_addr(i_vertex_index)),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    vna_ram #(
        .WIDTH (3*SW),
        .DEPTH (MAX_VERTICES)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (w_sum_waddr),
        .i_wdata (w_sum_wdata),
        .i_raddr (w_sum_raddr),
        .o_rdata (w_sum_rdata)
    );

    vna_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cross_start),
        .i_p0    (r_p0),
        .i_p1    (r_p1),
        .i_p2    (r_p2),
        .o_done  (w_cross_done),
        .o_vec   (w_cross_vec)
    );

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_norm_start),
        .i_vec   (r_norm_in),
        .o_done  (w_norm_done),
        .o_norm  (w_norm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cross_start <= 1'b0;
            r_norm_start  <= 1'b0;
            r_ovalid      <= 1'b0;
            r_k           <= '0;
        end else begin
            r_cross_start <= (r_state == S_FRD3);
            r_norm_start  <= w_norm_go;
            // Load a new result, or drop the current one once it is taken.
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ca  <= to_addr(i_corner_a);
                        r_cb  <= to_addr(i_corner_b);
                        r_cc  <= to_addr(i_corner_c);
                        r_idx <= i_vertex_index;
                        if (i_op == vna_pkg::OP_FACE && in_range(i_corner_a) &&
                            in_range(i_corner_b) && in_range(i_corner_c)) begin
                            r_state <= S_FRD0;
                        end else if (i_op == vna_pkg::OP_READ &&
                                     in_range(i_vertex_index)) begin
                            r_state <= S_RRD;
                        end
                    end
                end
                S_FRD0: r_state <= S_FRD1;
                S_FRD1: begin
                    r_p0    <= w_pos_rdata;
                    r_state <= S_FRD2;
                end
                S_FRD2: begin
                    r_p1    <= w_pos_rdata;
                    r_state <= S_FRD3;
                end
                S_FRD3: begin
                    r_p2    <= w_pos_rdata;
                    r_state <= S_FCROSS;
                end
                S_FCROSS: begin
                    if (w_cross_done) begin
                        if (w_cross_vec.mag == '0) begin
                            // degenerate face adds nothing
                            r_state <= S_IDLE;
                        end else begin
                            r_norm_in <= w_cross_vec;
                            r_state   <= S_FNORM;
                        end
                    end
                end
                S_FNORM: begin
                    if (w_norm_done) begin
                        r_n     <= w_norm;
                        r_k     <= '0;
                        r_state <= S_FSRD;
                    end
                end
                // Corners go strictly one after another, so a repeated corner
                // always reads the value written for the one before it.
                S_FSRD: r_state <= S_FSWR;
                S_FSWR: begin
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_FSRD;
                    end
                end
                S_RRD: r_state <= S_RCHK;
                S_RCHK: begin
                    if (w_sum_zero) begin
                        r_n     <= '0;
                        r_zero  <= 1'b1;
                        r_state <= S_ROUT;
                    end else begin
                        r_zero    <= 1'b0;
                        r_norm_in <= w_sum_vec;
                        r_state   <= S_RNORM;
                    end
                end
                S_RNORM: begin
                    if (w_norm_done) begin
                        r_n     <= w_norm;
                        r_state <= S_ROUT;
                    end
                end
                // Hold until the output register is free.
                S_ROUT: begin
                    if (w_out_load) begin
                        r_oidx  <= r_idx;
                        r_onorm <= r_n;
                        r_ozero <= r_zero;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_read_index = r_oidx;
    assign o_norm_x     = r_onorm[0];
    assign o_norm_y     = r_onorm[1];
    assign o_norm_z     = r_onorm[2];
    assign o_zero_sum   = r_ozero;

    a_cross_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cross_done |-> r_state == S_FCROSS)
        else $error("cross product finished outside face processing");

    a_norm_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm_done |-> (r_state == S_FNORM || r_state == S_RNORM))
        else $error("normalizer finished with no item waiting for it");

    a_sum_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum_we |-> (r_state == S_IDLE || r_state == S_FSWR))
        else $error("sum store written outside load or write-back");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_sum) |-> (o_norm_x == 0 && o_norm_y == 0 && o_norm_z == 0))
        else $error("zero sum result carries a nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_x <= vna_pkg::NORM_ONE && o_norm_x >= -vna_pkg::NORM_ONE &&
                     o_norm_y <= vna_pkg::NORM_ONE && o_norm_y >= -vna_pkg::NORM_ONE &&
                     o_norm_z <= vna_pkg::NORM_ONE && o_norm_z >= -vna_pkg::NORM_ONE))
        else $error("normal component outside unit range");

endmodule

// File: src/vna_ram.sv
// Generic single write port, single read port RAM with registered read data.
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vna_cross.sv
// Face edge cross product, one 33x33 multiplication per cycle.
module vna_cross (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [3*vna_pkg::POS_W-1:0] i_p0,
    input  logic [3*vna_pkg::POS_W-1:0] i_p1,
    input  logic [3*vna_pkg::POS_W-1:0] i_p2,
    output logic                        o_done,
    output vna_pkg::t_vec               o_vec
);

    localparam int PW = vna_pkg::POS_W;

    typedef logic signed [PW:0]     t_edge;
    typedef logic signed [2*PW+1:0] t_prod;
    typedef logic signed [2*PW+2:0] t_wide;

    t_edge      r_e1 [3];
    t_edge      r_e2 [3];
    t_prod      r_prod;
    t_wide      r_acc;
    t_wide      r_w  [3];
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       r_done;

    t_edge      w_a;
    t_edge      w_b;
    t_prod      w_prod;
    logic [2:0] w_prev;

    // Operand order: component k takes two products, the second subtracted.
    always_comb begin
        case (r_cnt)
            3'd0:    begin w_a = r_e1[1]; w_b = r_e2[2]; end
            3'd1:    begin w_a = r_e1[2]; w_b = r_e2[1]; end
            3'd2:    begin w_a = r_e1[2]; w_b = r_e2[0]; end
            3'd3:    begin w_a = r_e1[0]; w_b = r_e2[2]; end
            3'd4:    begin w_a = r_e1[0]; w_b = r_e2[1]; end
            3'd5:    begin w_a = r_e1[1]; w_b = r_e2[0]; end
            default: begin w_a = '0;      w_b = '0;      end
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_prev = r_cnt - 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 3'd6);
            if (!r_busy) begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= t_edge'(signed'(i_p1[i*PW +: PW]))
                                 - t_edge'(signed'(i_p0[i*PW +: PW]));
                        r_e2[i] <= t_edge'(signed'(i_p2[i*PW +: PW]))
                                 - t_edge'(signed'(i_p0[i*PW +: PW]));
                    end
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else begin
                if (r_cnt != 3'd6) begin
                    r_prod <= w_prod;
                end
                if (r_cnt != 3'd0) begin
                    if (!w_prev[0]) begin
                        r_acc <= t_wide'(r_prod);
                    end else begin
                        r_w[w_prev[2:1]] <= r_acc - t_wide'(r_prod);
                    end
                end
                if (r_cnt == 3'd6) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_comb begin
        t_wide abs_v;
        for (int i = 0; i < 3; i++) begin
            o_vec.neg[i] = r_w[i] < 0;
            abs_v        = o_vec.neg[i] ? -r_w[i] : r_w[i];
            o_vec.mag[i] = vna_pkg::t_mag'(abs_v);
        end
    end

    assign o_done = r_done;

endmodule

// File: src/vna_norm.sv
// Vector normalizer: scale search, sum of squares, square root, rounded division.
module vna_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  vna_pkg::t_vec  i_vec,
    output logic           o_done,
    output vna_pkg::t_nvec o_norm
);

    localparam int MW  = vna_pkg::MAG_W;
    localparam int SW  = vna_pkg::M_W;
    localparam int QW  = vna_pkg::Q_W;
    localparam int RW  = 2*SW + 3;        // root and bit registers
    localparam int LW  = SW + 1;          // vector length
    localparam int NW  = SW + QW;         // dividend

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SQ,
        S_ROOT,
        S_PREP,
        S_DIV
    } t_state;

    t_state               r_state;
    logic [2:0]           r_neg;
    logic [2:0][MW-1:0]   r_v;
    logic [3:0]           r_cnt;
    logic [2*SW-1:0]      r_sq;
    logic [2*SW+1:0]      r_s;
    logic [2*SW+1:0]      r_rem;
    logic [RW-1:0]        r_root;
    logic [RW-1:0]        r_bit;
    logic [NW-1:0]        r_num [3];
    logic [NW-1:0]        r_d;
    logic [QW-1:0]        r_q   [3];
    logic                 r_done;

    logic [MW-1:0]        w_or;
    logic [6:0]           w_amt;
    logic [SW-1:0]        w_m [3];
    logic [SW-1:0]        w_msel;
    logic [2*SW+1:0]      w_s_next;
    logic [RW-1:0]        w_rb;
    logic [LW-1:0]        w_len;

    assign w_or  = r_v[0] | r_v[1] | r_v[2];
    assign w_amt = 7'd64 >> r_cnt[2:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m[i] = r_v[i][MW-1 -: SW];
        end
        case (r_cnt[1:0])
            2'd0:    w_msel = w_m[0];
            2'd1:    w_msel = w_m[1];
            default: w_msel = w_m[2];
        endcase
    end

    assign w_s_next = r_s + (2*SW+2)'(r_sq);
    assign w_rb     = r_root + r_bit;
    assign w_len    = r_root[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state == S_DIV) && (r_cnt == 4'(QW - 1));
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_vec.neg;
                        r_v     <= i_vec.mag;
                        r_cnt   <= '0;
                        r_state <= S_SHIFT;
                    end
                end
                // Left-justify all three magnitudes by the same amount.
                S_SHIFT: begin
                    if ((w_or >> (MW - int'(w_amt))) == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_v[i] <= r_v[i] << w_amt;
                        end
                    end
                    if (r_cnt == 4'd6) begin
                        r_cnt   <= '0;
                        r_s     <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_SQ: begin
                    if (r_cnt != 4'd3) begin
                        r_sq <= w_msel * w_msel;
                    end
                    if (r_cnt != 4'd0) begin
                        r_s <= w_s_next;
                    end
                    if (r_cnt == 4'd3) begin
                        r_rem   <= w_s_next;
                        r_root  <= '0;
                        r_bit   <= RW'(1) << (RW - 1);
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                // One result bit per cycle.
                S_ROOT: begin
                    if (RW'(r_rem) >= w_rb) begin
                        r_rem  <= (2*SW+2)'(RW'(r_rem) - w_rb);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_num[i] <= NW'({w_m[i], {(QW-1){1'b0}}}) + NW'(w_len >> 1);
                    end
                    r_d     <= NW'({w_len, {(QW-1){1'b0}}});
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                // Three restoring dividers side by side, one quotient bit a cycle.
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_num[i] >= r_d) begin
                            r_num[i] <= r_num[i] - r_d;
                            r_q[i]   <= {r_q[i][QW-2:0], 1'b1};
                        end else begin
                            r_q[i]   <= {r_q[i][QW-2:0], 1'b0};
                        end
                    end
                    r_d <= r_d >> 1;
                    if (r_cnt == 4'(QW - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        vna_pkg::t_norm q;
        for (int i = 0; i < 3; i++) begin
            q         = vna_pkg::t_norm'({1'b0, r_q[i]});
            o_norm[i] = r_neg[i] ? -q : q;
        end
    end

    assign o_done = r_done;

endmodule

// File: bench/tb_vertex_normal_accumulator_top.sv
// Self-checking testbench for the vertex normal accumulator top level.
module tb_vertex_normal_accumulator_top;

    // Clock, reset and ports.
    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_op;
    logic [11:0]       i_vertex_index;
    logic [11:0]       i_corner_a;
    logic [11:0]       i_corner_b;
    logic [11:0]       i_corner_c;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic              o_valid;
    logic              i_stall;
    logic [11:0]       o_read_index;
    logic signed [15:0] o_norm_x;
    logic signed [15:0] o_norm_y;
    logic signed [15:0] o_norm_z;
    logic              o_zero_sum;

    localparam int NVERT   = 4096;
    localparam int SUM_W   = 24;
    localparam int SUM_MAX = (1 << (SUM_W - 1)) - 1;
    localparam int SUM_MIN = -(1 << (SUM_W - 1));
    localparam vna_pkg::t_op OP_NONE = 2'd3;   // unused code, dropped by the block

    // One expected read result.
    typedef struct {
        logic [11:0]     idx;
        vna_pkg::t_nvec  nrm;
        logic            zs;
    } t_normal_due;

    // Shadow copy of the block's stores.
    logic signed [31:0] pos_mem [NVERT][3];
    int                 sum_mem [NVERT][3];
    bit                 loaded  [NVERT];
    int                 loaded_list [$];

    t_normal_due normal_due [$];

    int  errors;
    int  n_loads, n_faces, n_reads, n_noise, n_results;
    bit  quiet;       // no idling on either side
    bit  hold_off;    // receiver holds off for a long stretch

    vertex_normal_accumulator_top #(
        .MAX_VERTICES (NVERT),
        .SUM_WIDTH    (SUM_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_vertex_index (i_vertex_index),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_index   (o_read_index),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_zero_sum     (o_zero_sum)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Integer square root, one result bit per pass.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a sign/magnitude vector so its largest magnitude lands in
    // [2^29, 2^30), then divide each component by the rounded-down length.
    function automatic vna_pkg::t_nvec unit_normal(input vna_pkg::t_vec v);
        int              bl;
        int              nb;
        longint unsigned m [3];
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        vna_pkg::t_mag   sh;
        vna_pkg::t_nvec  res;
        bl = 0;
        for (int i = 0; i < 3; i++) begin
            nb = 0;
            for (int k = vna_pkg::MAG_W - 1; k >= 0; k--) begin
                if (v.mag[i][k] && nb == 0) nb = k + 1;
            end
            if (nb > bl) bl = nb;
        end
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (bl > vna_pkg::M_W) sh = v.mag[i] >> (bl - vna_pkg::M_W);
            else                   sh = v.mag[i] << (vna_pkg::M_W - bl);
            m[i] = sh[63:0];
            s = s + m[i] * m[i];
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * vna_pkg::NORM_ONE + len / 2) / len;
            res[i] = v.neg[i] ? -$signed(q[15:0]) : $signed(q[15:0]);
        end
        return res;
    endfunction

    function automatic int clamp_sum(input int a, input int b);
        longint r;
        r = longint'(a) + longint'(b);
        if (r > SUM_MAX) r = SUM_MAX;
        if (r < SUM_MIN) r = SUM_MIN;
        return int'(r);
    endfunction

    // Advance the shadow stores by one accepted transfer.
    task automatic predict_normals(input vna_pkg::t_op op, input int vi, input int ca,
                                   input int cb, input int cc,
                                   input logic signed [31:0] px,
                                   input logic signed [31:0] py,
                                   input logic signed [31:0] pz);
        logic signed [67:0] e1 [3];
        logic signed [67:0] e2 [3];
        logic signed [67:0] cr [3];
        logic signed [67:0] t;
        vna_pkg::t_vec  v;
        vna_pkg::t_nvec n;
        t_normal_due    d;
        int             crn [3];
        case (op)
            vna_pkg::OP_LOAD: begin
                pos_mem[vi][0] = px;
                pos_mem[vi][1] = py;
                pos_mem[vi][2] = pz;
                for (int i = 0; i < 3; i++) sum_mem[vi][i] = 0;
                if (!loaded[vi]) loaded_list = {loaded_list, vi};
                loaded[vi] = 1'b1;
                n_loads++;
            end
            vna_pkg::OP_FACE: begin
                crn[0] = ca;
                crn[1] = cb;
                crn[2] = cc;
                for (int i = 0; i < 3; i++) begin
                    e1[i] = 68'(pos_mem[cb][i]) - 68'(pos_mem[ca][i]);
                    e2[i] = 68'(pos_mem[cc][i]) - 68'(pos_mem[ca][i]);
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                n_faces++;
                if (cr[0] != 0 || cr[1] != 0 || cr[2] != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        v.neg[i] = cr[i] < 0;
                        t = v.neg[i] ? -cr[i] : cr[i];
                        v.mag[i] = t[vna_pkg::MAG_W-1:0];
                    end
                    n = unit_normal(v);
                    for (int k = 0; k < 3; k++)
                        for (int i = 0; i < 3; i++)
                            sum_mem[crn[k]][i] = clamp_sum(sum_mem[crn[k]][i],
                                                           int'(n[i]));
                end
            end
            vna_pkg::OP_READ: begin
                d.idx = 12'(vi);
                d.zs  = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    v.neg[i] = sum_mem[vi][i] < 0;
                    v.mag[i] = vna_pkg::MAG_W'(v.neg[i] ? -sum_mem[vi][i] : sum_mem[vi][i]);
                    if (sum_mem[vi][i] != 0) d.zs = 1'b0;
                end
                d.nrm = d.zs ? '0 : unit_normal(v);
                normal_due = {normal_due, d};
                n_reads++;
            end
            default: n_noise++;
        endcase
    endtask

    // Offer one transfer at the falling edge and hold it until accepted.
    task automatic send_item(input vna_pkg::t_op op, input int vi, input int ca, input int cb,
                             input int cc, input logic signed [31:0] px,
                             input logic signed [31:0] py,
                             input logic signed [31:0] pz);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_op           = op;
        i_vertex_index = 12'(vi);
        i_corner_a     = 12'(ca);
        i_corner_b     = 12'(cb);
        i_corner_c     = 12'(cc);
        i_pos_x        = px;
        i_pos_y        = py;
        i_pos_z        = pz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_normals(op, vi, ca, cb, cc, px, py, pz);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic int rnd_idx();
        return $urandom_range(0, NVERT - 1);
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // Mix of full-range and small coordinates.
    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 4095)) - 2048;
            2:       return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                            ^ $signed(32'($urandom_range(0, 255)));
        endcase
    endfunction

    // Directed: coordinate extremes, degenerate faces, zero sums, dropped code.
    task automatic test_directed();
        send_item(vna_pkg::OP_LOAD, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_item(vna_pkg::OP_LOAD, 1, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF);
        send_item(vna_pkg::OP_LOAD, 4095, 0, 0, 0, 0, 0, 32'sh8000_0000);
        send_item(vna_pkg::OP_LOAD, 2, 0, 0, 0, 32'sh0001_0000, 0, 0);
        send_item(vna_pkg::OP_LOAD, 3, 0, 0, 0, 0, 32'sh0001_0000, 0);
        send_item(vna_pkg::OP_READ, 4095, 0, 0, 0, 0, 0, 0);         // zero sum
        send_item(vna_pkg::OP_FACE, 0, 2, 2, 2, 0, 0, 0);            // all corners equal
        send_item(vna_pkg::OP_FACE, 0, 2, 3, 2, 0, 0, 0);            // repeated corner
        send_item(vna_pkg::OP_FACE, 0, 0, 1, 4095, 0, 0, 0);         // widest product
        send_item(vna_pkg::OP_FACE, 0, 4095, 2, 3, 0, 0, 0);
        send_item(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_READ, 4095, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 0);
        send_item(OP_NONE, 4095, 4095, 4095, 4095, -1, -1, -1);
        send_item(vna_pkg::OP_LOAD, 0, 0, 0, 0, 1, 2, 3);            // reload clears sum
        send_item(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_READ, 3, 0, 0, 0, 0, 0, 0);
    endtask

    // Drive six vertex sums into both clamps with axis-aligned faces.
    task automatic test_saturation();
        send_item(vna_pkg::OP_LOAD, 10, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_LOAD, 11, 0, 0, 0, 32'sh0001_0000, 0, 0);
        send_item(vna_pkg::OP_LOAD, 12, 0, 0, 0, 0, 32'sh0001_0000, 0);
        send_item(vna_pkg::OP_LOAD, 13, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_LOAD, 14, 0, 0, 0, 32'sh0001_0000, 0, 0);
        send_item(vna_pkg::OP_LOAD, 15, 0, 0, 0, 0, 32'sh0001_0000, 0);
        for (int k = 0; k < 514; k++) begin
            send_item(vna_pkg::OP_FACE, 0, 10, 11, 12, 0, 0, 0);
            send_item(vna_pkg::OP_FACE, 0, 13, 15, 14, 0, 0, 0);
        end
        send_item(vna_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_READ, 14, 0, 0, 0, 0, 0, 0);
        send_item(vna_pkg::OP_FACE, 0, 10, 12, 11, 0, 0, 0);         // step back off the clamp
        send_item(vna_pkg::OP_READ, 11, 0, 0, 0, 0, 0, 0);
    endtask

    // Hold the result side off while reads keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int k = 0; k < 12; k++)
            send_item(vna_pkg::OP_READ, pick_loaded(), 0, 0, 0, 0, 0, 0);
        hold_off = 1'b0;
    endtask

    // Random mix of loads, faces over loaded vertices, reads, and noise.
    task automatic test_random(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            if (k >= count - count / 3) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 22 || loaded_list.size() < 3)
                send_item(vna_pkg::OP_LOAD, ($urandom_range(0, 1) ? rnd_idx()
                                             : $urandom_range(0, 63)),
                          rnd_idx(), rnd_idx(), rnd_idx(),
                          rnd_coord(), rnd_coord(), rnd_coord());
            else if (r < 65)
                send_item(vna_pkg::OP_FACE, rnd_idx(), pick_loaded(), pick_loaded(),
                          pick_loaded(), $urandom, $urandom, $urandom);
            else if (r < 97)
                send_item(vna_pkg::OP_READ, pick_loaded(), rnd_idx(), rnd_idx(), rnd_idx(),
                          $urandom, $urandom, $urandom);
            else
                send_item(OP_NONE, rnd_idx(), rnd_idx(), rnd_idx(), rnd_idx(),
                          $urandom, $urandom, $urandom);
        end
    endtask

    // Receiver: random stall bursts, a long hold-off on request, none when quiet.
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall = 1'b1;
                repeat (400) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                burst = $urandom_range(1, 8);
                repeat (burst - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest expected normal.
    always @(posedge i_clk) begin
        t_normal_due d;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (normal_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result idx=%0d", $time, o_read_index);
            end else begin
                d = normal_due.pop_front();
                if (o_read_index !== d.idx || o_norm_x !== d.nrm[0] ||
                    o_norm_y !== d.nrm[1] || o_norm_z !== d.nrm[2] ||
                    o_zero_sum !== d.zs) begin
                    errors++;
                    $display("%0t: mismatch expected idx=%0d n=(%0d,%0d,%0d) z=%0b",
                             $time, d.idx, d.nrm[0], d.nrm[1], d.nrm[2], d.zs);
                    $display("%0t:          actual   idx=%0d n=(%0d,%0d,%0d) z=%0b",
                             $time, o_read_index, o_norm_x, o_norm_y, o_norm_z,
                             o_zero_sum);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #30_000_000;
        $display("tb_vertex_normal_accumulator_top failed");
        $finish;
    end

    initial begin
        int wait_cnt;
        errors = 0;
        n_loads = 0;
        n_faces = 0;
        n_reads = 0;
        n_noise = 0;
        n_results = 0;
        quiet = 1'b0;
        hold_off = 1'b0;
        for (int i = 0; i < NVERT; i++) loaded[i] = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = vna_pkg::OP_LOAD;
        i_vertex_index = '0;
        i_corner_a = '0;
        i_corner_b = '0;
        i_corner_c = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_backpressure();
        test_random(160);

        // Drain, then let a trailing face finish.
        wait_cnt = 0;
        while (normal_due.size() != 0 && wait_cnt < 100_000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (normal_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, normal_due.size());
        end
        repeat (200) @(posedge i_clk);

        $display("Covered %0d loads, %0d faces, %0d reads, %0d dropped items;",
                 n_loads, n_faces, n_reads, n_noise);
        $display("checked %0d normals, with both sum clamps and a long output hold-off.",
                 n_results);
        if (errors == 0)
            $display("tb_vertex_normal_accumulator_top passed");
        else
            $display("tb_vertex_normal_accumulator_top failed");
        $finish;
    end

endmodule
